// ===== hw/rtl/fsr_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helpers for the fit-and-scale RGB565 writer.
// No dependencies; used by every other file of the block.
package fsr_pkg;

  // Screen geometry and source limits
  localparam int ScreenWidth  = 320;
  localparam int ScreenHeight = 240;
  localparam int MaxSourceDim = 4095;

  // Field widths
  localparam int ChanW    = 8;
  localparam int ColorW   = 16;
  localparam int IdxW     = 17;
  localparam int SrcW     = 12;
  localparam int PosW     = 11;
  localparam int BoxW     = 10;
  localparam int OrgW     = 12;
  localparam int ScrW     = 13;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 12;

  // Shared multiply-divide unit: quotient bits and step counter
  localparam int QuotW    = 12;
  localparam int ProdW    = 2 * QuotW;
  localparam int StepCntW = $clog2(QuotW + 1);

  // Pixel queue between front and back
  localparam int QDepth = 2;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  // Register reset values
  localparam int RstSrcWidth  = 320;
  localparam int RstSrcHeight = 240;
  localparam int RstBoxWidth  = 320;
  localparam int RstBoxHeight = 240;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SOURCE_WIDTH  = 3'd0,
    REG_SOURCE_HEIGHT = 3'd1,
    REG_BOX_LEFT      = 3'd2,
    REG_BOX_TOP       = 3'd3,
    REG_BOX_WIDTH     = 3'd4,
    REG_BOX_HEIGHT    = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [SrcW-1:0] source_width;
    logic [SrcW-1:0] source_height;
    logic [PosW-1:0] box_left;
    logic [PosW-1:0] box_top;
    logic [BoxW-1:0] box_width;
    logic [BoxW-1:0] box_height;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [QuotW-1:0] a;
    logic [QuotW-1:0] b;
    logic [QuotW-1:0] d;
  } md_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [QuotW-1:0] q;
  } md_rsp_t;

  typedef struct packed {
    logic              valid;
    logic [ColorW-1:0] color;
  } q_head_t;

  function automatic logic [ColorW-1:0] pack565(input logic [ChanW-1:0] r,
                                                input logic [ChanW-1:0] g,
                                                input logic [ChanW-1:0] b);
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

endpackage

// ===== hw/rtl/fsr_intf.sv =====
`timescale 1ns / 1ps
// Handshake channels of the block: source pixels, framebuffer writes, register writes.
// Depends on fsr_pkg for field widths.
interface fsr_pix_if;
  logic                      valid;
  logic                      ready;
  logic [fsr_pkg::ChanW-1:0] red;
  logic [fsr_pkg::ChanW-1:0] green;
  logic [fsr_pkg::ChanW-1:0] blue;
  modport source (output valid, red, green, blue, input ready);
  modport sink (input valid, red, green, blue, output ready);
endinterface

interface fsr_wr_if;
  logic                       valid;
  logic                       ready;
  logic [fsr_pkg::IdxW-1:0]   pixel_index;
  logic [fsr_pkg::ColorW-1:0] color;
  logic                       frame_last;
  modport source (output valid, pixel_index, color, frame_last, input ready);
  modport sink (input valid, pixel_index, color, frame_last, output ready);
endinterface

interface fsr_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [fsr_pkg::CfgIdxW-1:0]  index;
  logic [fsr_pkg::CfgDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/fsr_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts source pixel beats, packs them to RGB565, holds them in a short queue.
// Depends on fsr_pkg and fsr_intf.
module fsr_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  fsr_pix_if.sink          in_i,
  output fsr_pkg::q_head_t head_o,
  input  logic             pop_i
);

  logic [fsr_pkg::ColorW-1:0] mem_q [fsr_pkg::QDepth];
  logic [fsr_pkg::QPtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [fsr_pkg::QCntW-1:0]  cnt_q, cnt_d;
  logic                       push;

  assign in_i.ready = (cnt_q != fsr_pkg::QCntW'(fsr_pkg::QDepth));
  assign push       = in_i.valid && in_i.ready;

  assign head_o.valid = (cnt_q != '0);
  assign head_o.color = mem_q[rd_ptr_q];

  always_comb begin
    case ({push, pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= fsr_pkg::pack565(in_i.red, in_i.green, in_i.blue);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== hw/rtl/fsr_muldiv.sv =====
`timescale 1ns / 1ps
// Shared unit: registers a*b, then divides by d one quotient bit per cycle.
// Depends on fsr_pkg. Caller guarantees the quotient fits in QuotW bits and d != 0.
module fsr_muldiv (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  fsr_pkg::md_req_t req_i,
  output fsr_pkg::md_rsp_t rsp_o
);

  logic                         busy_q, done_q;
  logic [fsr_pkg::StepCntW-1:0] cnt_q;
  logic [fsr_pkg::ProdW-1:0]    acc_q;
  logic [fsr_pkg::QuotW-1:0]    d_q;
  logic [fsr_pkg::QuotW:0]      trial, diff;
  logic                         ge;
  logic [fsr_pkg::QuotW-1:0]    rem_next;

  // Partial remainder with the next numerator bit shifted in
  assign trial    = {acc_q[fsr_pkg::ProdW-1:fsr_pkg::QuotW], acc_q[fsr_pkg::QuotW-1]};
  assign ge       = (trial >= {1'b0, d_q});
  assign diff     = trial - {1'b0, d_q};
  assign rem_next = ge ? diff[fsr_pkg::QuotW-1:0] : trial[fsr_pkg::QuotW-1:0];

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.q    = acc_q[fsr_pkg::QuotW-1:0];

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      acc_q <= fsr_pkg::ProdW'(req_i.a) * fsr_pkg::ProdW'(req_i.b);
      d_q   <= req_i.d;
    end else if (busy_q) begin
      acc_q <= {rem_next, acc_q[fsr_pkg::QuotW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == fsr_pkg::StepCntW'(1));
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= fsr_pkg::StepCntW'(fsr_pkg::QuotW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == fsr_pkg::StepCntW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/fsr_back.sv =====
`timescale 1ns / 1ps
// Back end: fits the image at its first pixel, tracks sampling positions, emits writes.
// Depends on fsr_pkg, fsr_intf; drives the shared fsr_muldiv unit.
module fsr_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  fsr_pkg::cfg_t    cfg_i,
  input  fsr_pkg::q_head_t head_i,
  output logic             pop_o,
  output fsr_pkg::md_req_t md_req_o,
  input  fsr_pkg::md_rsp_t md_rsp_i,
  fsr_wr_if.source         out_o
);

  localparam logic [2:0] StIdle     = 3'd0;
  localparam logic [2:0] StFit1     = 3'd1;
  localparam logic [2:0] StFit1Wait = 3'd2;
  localparam logic [2:0] StFit2     = 3'd3;
  localparam logic [2:0] StFit2Wait = 3'd4;
  localparam logic [2:0] StFitDone  = 3'd5;
  localparam logic [2:0] StEval     = 3'd6;
  localparam logic [2:0] StDivWait  = 3'd7;

  localparam int SrcW = fsr_pkg::SrcW;
  localparam int BoxW = fsr_pkg::BoxW;
  localparam int OrgW = fsr_pkg::OrgW;
  localparam int ScrW = fsr_pkg::ScrW;

  logic [2:0]                 state_q, state_d;
  logic [fsr_pkg::ColorW-1:0] color_q, color_d;
  logic [SrcW-1:0]            src_col_q, src_col_d, src_row_q, src_row_d;
  logic [BoxW-1:0]            out_col_q, out_col_d, out_row_q, out_row_d;
  logic [SrcW-1:0]            want_col_q, want_col_d, want_row_q, want_row_d;
  logic [BoxW-1:0]            fit_w_q, fit_w_d, fit_h_q, fit_h_d;
  logic [OrgW-1:0]            org_x_q, org_x_d, org_y_q, org_y_d;
  logic [SrcW-1:0]            tw_q, tw_d, th_q, th_d;
  logic                       div_row_q, div_row_d;
  logic                       out_valid_q, out_valid_d;
  logic [fsr_pkg::IdxW-1:0]   out_idx_q, out_idx_d;
  logic [fsr_pkg::ColorW-1:0] out_color_q, out_color_d;
  logic                       out_last_q, out_last_d;

  logic [SrcW-1:0] w, h;
  logic [BoxW-1:0] bw, bh;
  logic [BoxW-1:0] fw_new, fh_new;
  logic [BoxW-1:0] pad_x, pad_y;
  logic            row_end, img_end, row_used, sample, visible, stall;
  logic [ScrW-1:0] dx, dy;
  logic [2*ScrW-1:0] idx_full;

  function automatic logic [SrcW-1:0] src_dim(input logic [SrcW-1:0] v);
    if (v == '0) return SrcW'(1);
    if (v > SrcW'(fsr_pkg::MaxSourceDim)) return SrcW'(fsr_pkg::MaxSourceDim);
    return v;
  endfunction

  assign w  = src_dim(cfg_i.source_width);
  assign h  = src_dim(cfg_i.source_height);
  assign bw = (cfg_i.box_width == '0) ? BoxW'(1) : cfg_i.box_width;
  assign bh = (cfg_i.box_height == '0) ? BoxW'(1) : cfg_i.box_height;

  // Fitted size with a floor of one; tw and th are within the box here
  assign fw_new = (tw_q == '0) ? BoxW'(1) : tw_q[BoxW-1:0];
  assign fh_new = (th_q == '0) ? BoxW'(1) : th_q[BoxW-1:0];
  assign pad_x  = bw - fw_new;
  assign pad_y  = bh - fh_new;

  assign row_end  = (src_col_q >= w - SrcW'(1));
  assign img_end  = row_end && (src_row_q >= h - SrcW'(1));
  assign row_used = (src_row_q == want_row_q) && (out_row_q < fit_h_q);
  assign sample   = row_used && (src_col_q == want_col_q) && (out_col_q < fit_w_q);

  assign dx = {org_x_q[OrgW-1], org_x_q} + {{(ScrW - BoxW){1'b0}}, out_col_q};
  assign dy = {org_y_q[OrgW-1], org_y_q} + {{(ScrW - BoxW){1'b0}}, out_row_q};
  assign visible = !dx[ScrW-1] && (dx < ScrW'(fsr_pkg::ScreenWidth)) &&
                   !dy[ScrW-1] && (dy < ScrW'(fsr_pkg::ScreenHeight));
  assign idx_full = (2*ScrW)'(dy) * (2*ScrW)'(fsr_pkg::ScreenWidth) + (2*ScrW)'(dx);

  // Hold the pixel while an earlier write still waits in the output register
  assign stall = sample && visible && out_valid_q && !out_o.ready;

  assign out_o.valid       = out_valid_q;
  assign out_o.pixel_index = out_idx_q;
  assign out_o.color       = out_color_q;
  assign out_o.frame_last  = out_last_q;

  always_comb begin
    state_d     = state_q;
    color_d     = color_q;
    src_col_d   = src_col_q;
    src_row_d   = src_row_q;
    out_col_d   = out_col_q;
    out_row_d   = out_row_q;
    want_col_d  = want_col_q;
    want_row_d  = want_row_q;
    fit_w_d     = fit_w_q;
    fit_h_d     = fit_h_q;
    org_x_d     = org_x_q;
    org_y_d     = org_y_q;
    tw_d        = tw_q;
    th_d        = th_q;
    div_row_d   = div_row_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_idx_d   = out_idx_q;
    out_color_d = out_color_q;
    out_last_d  = out_last_q;
    pop_o       = 1'b0;
    md_req_o    = '0;

    case (state_q)
      StIdle: begin
        if (head_i.valid) begin
          pop_o   = 1'b1;
          color_d = head_i.color;
          if (src_col_q == '0 && src_row_q == '0) begin
            tw_d    = w;
            th_d    = h;
            state_d = StFit1;
          end else begin
            state_d = StEval;
          end
        end
      end
      StFit1: begin
        // Limit width first
        if (tw_q > SrcW'(bw)) begin
          md_req_o.start = 1'b1;
          md_req_o.a     = th_q;
          md_req_o.b     = SrcW'(bw);
          md_req_o.d     = tw_q;
          state_d        = StFit1Wait;
        end else begin
          state_d = StFit2;
        end
      end
      StFit1Wait: begin
        if (md_rsp_i.done) begin
          th_d    = md_rsp_i.q;
          tw_d    = SrcW'(bw);
          state_d = StFit2;
        end
      end
      StFit2: begin
        if (th_q > SrcW'(bh)) begin
          md_req_o.start = 1'b1;
          md_req_o.a     = tw_q;
          md_req_o.b     = SrcW'(bh);
          md_req_o.d     = th_q;
          state_d        = StFit2Wait;
        end else begin
          state_d = StFitDone;
        end
      end
      StFit2Wait: begin
        if (md_rsp_i.done) begin
          tw_d    = md_rsp_i.q;
          th_d    = SrcW'(bh);
          state_d = StFitDone;
        end
      end
      StFitDone: begin
        fit_w_d    = fw_new;
        fit_h_d    = fh_new;
        org_x_d    = {cfg_i.box_left[fsr_pkg::PosW-1], cfg_i.box_left} +
                     OrgW'(pad_x[BoxW-1:1]);
        org_y_d    = {cfg_i.box_top[fsr_pkg::PosW-1], cfg_i.box_top} +
                     OrgW'(pad_y[BoxW-1:1]);
        out_col_d  = '0;
        out_row_d  = '0;
        want_col_d = '0;
        want_row_d = '0;
        state_d    = StEval;
      end
      StEval: begin
        if (!stall) begin
          state_d = StIdle;
          if (sample) begin
            out_col_d = out_col_q + 1'b1;
            if (visible) begin
              out_valid_d = 1'b1;
              out_idx_d   = idx_full[fsr_pkg::IdxW-1:0];
              out_color_d = color_q;
              out_last_d  = img_end;
            end
          end
          if (row_end) begin
            out_col_d  = '0;
            want_col_d = '0;
            src_col_d  = '0;
            src_row_d  = img_end ? '0 : src_row_q + 1'b1;
            if (row_used) begin
              out_row_d      = out_row_q + 1'b1;
              md_req_o.start = 1'b1;
              md_req_o.a     = SrcW'({1'b0, out_row_q} + 1'b1);
              md_req_o.b     = h;
              md_req_o.d     = SrcW'(fit_h_q);
              div_row_d      = 1'b1;
              state_d        = StDivWait;
            end
          end else begin
            src_col_d = src_col_q + 1'b1;
            if (sample) begin
              md_req_o.start = 1'b1;
              md_req_o.a     = SrcW'({1'b0, out_col_q} + 1'b1);
              md_req_o.b     = w;
              md_req_o.d     = SrcW'(fit_w_q);
              div_row_d      = 1'b0;
              state_d        = StDivWait;
            end
          end
        end
      end
      StDivWait: begin
        if (md_rsp_i.done) begin
          if (div_row_q) begin
            want_row_d = md_rsp_i.q;
          end else begin
            want_col_d = md_rsp_i.q;
          end
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    color_q     <= color_d;
    tw_q        <= tw_d;
    th_q        <= th_d;
    div_row_q   <= div_row_d;
    out_idx_q   <= out_idx_d;
    out_color_q <= out_color_d;
    out_last_q  <= out_last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      src_col_q   <= '0;
      src_row_q   <= '0;
      out_col_q   <= '0;
      out_row_q   <= '0;
      want_col_q  <= '0;
      want_row_q  <= '0;
      fit_w_q     <= '0;
      fit_h_q     <= '0;
      org_x_q     <= '0;
      org_y_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      src_col_q   <= src_col_d;
      src_row_q   <= src_row_d;
      out_col_q   <= out_col_d;
      out_row_q   <= out_row_d;
      want_col_q  <= want_col_d;
      want_row_q  <= want_row_d;
      fit_w_q     <= fit_w_d;
      fit_h_q     <= fit_h_d;
      org_x_q     <= org_x_d;
      org_y_q     <= org_y_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== hw/rtl/fit_scale_rgb_to_rgb565.sv =====
`timescale 1ns / 1ps
// Path: an accepted beat passes the queue, the pop and evaluate states and the output register.
// Every pixel is popped and evaluated; one that starts a division (a sampled pixel
//   or the end of a used row) also waits for the multiply, 12 divide steps and the done flag.
// The first pixel of an image also runs the fit; a held write stalls the back.
// Reset: asynchronous, active low; registers return to defaults, positions clear, queue empties.
// Depends on fsr_pkg, fsr_intf, fsr_front, fsr_muldiv and fsr_back.
module fit_scale_rgb_to_rgb565 (
  input  logic     clk_i,
  input  logic     rst_ni,
  fsr_cfg_if.sink  cfg_i,
  fsr_pix_if.sink  in_i,
  fsr_wr_if.source out_o
);

  fsr_pkg::cfg_t    cfg_q;
  fsr_pkg::q_head_t head;
  fsr_pkg::md_req_t md_req;
  fsr_pkg::md_rsp_t md_rsp;
  logic             pop;

  // Register file: writes are always taken; an unknown index is dropped.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.source_width  <= fsr_pkg::SrcW'(fsr_pkg::RstSrcWidth);
      cfg_q.source_height <= fsr_pkg::SrcW'(fsr_pkg::RstSrcHeight);
      cfg_q.box_left      <= '0;
      cfg_q.box_top       <= '0;
      cfg_q.box_width     <= fsr_pkg::BoxW'(fsr_pkg::RstBoxWidth);
      cfg_q.box_height    <= fsr_pkg::BoxW'(fsr_pkg::RstBoxHeight);
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (fsr_pkg::cfg_reg_e'(cfg_i.index))
        fsr_pkg::REG_SOURCE_WIDTH:  cfg_q.source_width  <= cfg_i.data[fsr_pkg::SrcW-1:0];
        fsr_pkg::REG_SOURCE_HEIGHT: cfg_q.source_height <= cfg_i.data[fsr_pkg::SrcW-1:0];
        fsr_pkg::REG_BOX_LEFT:      cfg_q.box_left      <= cfg_i.data[fsr_pkg::PosW-1:0];
        fsr_pkg::REG_BOX_TOP:       cfg_q.box_top       <= cfg_i.data[fsr_pkg::PosW-1:0];
        fsr_pkg::REG_BOX_WIDTH:     cfg_q.box_width     <= cfg_i.data[fsr_pkg::BoxW-1:0];
        fsr_pkg::REG_BOX_HEIGHT:    cfg_q.box_height    <= cfg_i.data[fsr_pkg::BoxW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Front: take pixel beats, pack to RGB565, queue them for the back end.
  fsr_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .head_o (head),
    .pop_i  (pop)
  );

  // Shared multiply then divide, used for the fit and for each next sample position.
  fsr_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (md_req),
    .rsp_o  (md_rsp)
  );

  // Back: walk the source raster, pick sampled pixels, clip and emit writes.
  fsr_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .head_i   (head),
    .pop_o    (pop),
    .md_req_o (md_req),
    .md_rsp_i (md_rsp),
    .out_o    (out_o)
  );

`ifndef SYNTHESIS
  a_md_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    md_req.start |-> !md_rsp.busy)
    else $error("muldiv started while busy");

  a_md_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    md_rsp.done |-> (!md_rsp.busy && $past(md_rsp.busy)))
    else $error("muldiv done without a finished run");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> head.valid)
    else $error("pixel queue popped while empty");
`endif

endmodule

// ===== bench/fit_scale_rgb_to_rgb565_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for fit_scale_rgb_to_rgb565: streams RGB888 source pixels and checks
// every RGB565 framebuffer write against a cycle-free predictor of the fit, sampling and clip.
// Depends on fsr_pkg, fsr_intf and the RTL of the block.
module fit_scale_rgb_to_rgb565_tb;
  import fsr_pkg::*;

  // Run shaping
  localparam int RandomBeats   = 1950;    // source beats in the random part
  localparam int QuietTail     = 300;     // last beats of the random part run without idling
  localparam int SettleCycles  = 120;     // covers the first-pixel fit plus a sampled pixel
  localparam int HoldOffCycles = 300;     // long output hold-off of the pressure test
  localparam int CycleLimit    = 1000000;

  typedef struct packed {
    logic [IdxW-1:0]   pixel_index;
    logic [ColorW-1:0] color;
    logic              frame_last;
  } fb_write_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  fsr_cfg_if cfg_if ();
  fsr_pix_if pix_if ();
  fsr_wr_if  wr_if ();

  fit_scale_rgb_to_rgb565 dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (pix_if),
    .out_o  (wr_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Expected framebuffer writes, oldest first
  fb_write_t pending_writes[$];
  fb_write_t head_write;

  // Bench copy of the register file
  logic [SrcW-1:0]        cfg_src_w, cfg_src_h;
  logic signed [PosW-1:0] cfg_box_left, cfg_box_top;
  logic [BoxW-1:0]        cfg_box_w, cfg_box_h;

  // Predictor state: source position, output position, sampled source position, fit
  int unsigned img_col, img_row, dst_col, dst_row, pick_col, pick_row;
  int unsigned fit_w, fit_h;
  int          org_x, org_y;

  // Bookkeeping
  int  fail_count;
  int  writes_checked;
  int  pixel_beats;
  int  images_started;
  int  cfg_writes;
  int  cycle_count;
  int  stall_left;
  int  hold_off_asked;
  int  hold_off_served;
  bit  quiet_tail;

  // Register write as seen by the block: drop the bits above each register's width.
  task automatic apply_config(input cfg_reg_e idx, input logic [CfgDataW-1:0] data);
    case (idx)
      REG_SOURCE_WIDTH:  cfg_src_w = data[SrcW-1:0];
      REG_SOURCE_HEIGHT: cfg_src_h = data[SrcW-1:0];
      REG_BOX_LEFT:      cfg_box_left = data[PosW-1:0];
      REG_BOX_TOP:       cfg_box_top = data[PosW-1:0];
      REG_BOX_WIDTH:     cfg_box_w = data[BoxW-1:0];
      REG_BOX_HEIGHT:    cfg_box_h = data[BoxW-1:0];
      default: ;
    endcase
  endtask

  // Advance the predictor by one accepted source pixel; queue the write it causes, if any.
  task automatic predict_write(input logic [3*ChanW-1:0] rgb);
    int unsigned w, h, bw, bh, tw, th;
    bit          row_end, img_end, row_used;
    int          dx, dy;
    fb_write_t   wr;
    // A zero size counts as one; a 12-bit source size can never pass MaxSourceDim.
    w = (cfg_src_w == 0) ? 1 : int'(cfg_src_w);
    h = (cfg_src_h == 0) ? 1 : int'(cfg_src_h);
    if (img_col == 0 && img_row == 0) begin
      // Fit at image start: limit width first, then height, truncating, at least 1.
      bw = (cfg_box_w == 0) ? 1 : int'(cfg_box_w);
      bh = (cfg_box_h == 0) ? 1 : int'(cfg_box_h);
      tw = w;
      th = h;
      if (tw > bw) begin
        th = th * bw / tw;
        tw = bw;
      end
      if (th > bh) begin
        tw = tw * bh / th;
        th = bh;
      end
      if (tw < 1) tw = 1;
      if (th < 1) th = 1;
      fit_w = tw;
      fit_h = th;
      org_x = int'(cfg_box_left) + int'((bw - tw) / 2);
      org_y = int'(cfg_box_top) + int'((bh - th) / 2);
      dst_col = 0;
      dst_row = 0;
      pick_col = 0;
      pick_row = 0;
      images_started++;
    end
    // End detection uses the live source size, so a position past the end counts too.
    row_end  = img_col >= w - 1;
    img_end  = row_end && img_row >= h - 1;
    row_used = (img_row == pick_row) && (dst_row < fit_h);
    if (row_used && img_col == pick_col && dst_col < fit_w) begin
      dx = org_x + int'(dst_col);
      dy = org_y + int'(dst_row);
      // Drop sampled pixels that fall off the screen.
      if (dx >= 0 && dx < ScreenWidth && dy >= 0 && dy < ScreenHeight) begin
        wr.pixel_index = IdxW'(dy * ScreenWidth + dx);
        wr.color       = {rgb[23:19], rgb[15:10], rgb[7:3]};
        wr.frame_last  = img_end;
        pending_writes.push_back(wr);
      end
      dst_col++;
      pick_col = dst_col * w / fit_w;
    end
    if (row_end) begin
      if (row_used) begin
        dst_row++;
        pick_row = dst_row * h / fit_h;
      end
      dst_col  = 0;
      pick_col = 0;
      img_col  = 0;
      img_row  = img_end ? 0 : (img_row + 1) % 4096;
    end else begin
      img_col = (img_col + 1) % 4096;
    end
  endtask

  // One register beat; only called while the block is idle. Valid drops again after each beat.
  task automatic write_reg(input cfg_reg_e idx, input logic [CfgDataW-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    apply_config(idx, data);
    cfg_writes++;
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_source(input int w, input int h);
    write_reg(REG_SOURCE_WIDTH, CfgDataW'(w));
    write_reg(REG_SOURCE_HEIGHT, CfgDataW'(h));
  endtask

  // Fill the unused top bits with noise; the block must ignore them.
  task automatic set_box(input int left, input int top, input int wd, input int ht);
    write_reg(REG_BOX_LEFT, {1'($urandom_range(0, 1)), 11'(left)});
    write_reg(REG_BOX_TOP, {1'($urandom_range(0, 1)), 11'(top)});
    write_reg(REG_BOX_WIDTH, {2'($urandom_range(0, 3)), 10'(wd)});
    write_reg(REG_BOX_HEIGHT, {2'($urandom_range(0, 3)), 10'(ht)});
  endtask

  // Offer one source pixel, with a random gap before it unless in the quiet tail.
  task automatic send_pixel(input logic [3*ChanW-1:0] rgb);
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      pix_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    pix_if.valid <= 1'b1;
    pix_if.red   <= rgb[23:16];
    pix_if.green <= rgb[15:8];
    pix_if.blue  <= rgb[7:0];
    do @(posedge clk_i); while (!pix_if.ready);
    pixel_beats++;
    predict_write(rgb);
  endtask

  // Send random pixels until the current image ends (a partly sent image is finished too).
  task automatic send_image();
    do send_pixel(24'($urandom)); while (!(img_col == 0 && img_row == 0));
  endtask

  // Drop valid, wait for every expected write, then let any skipped pixels work through.
  task automatic wait_for_writes();
    pix_if.valid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Reset registers: full 320x240 fit, every pixel sampled in place. Then shrink the source
  // to zero size mid-image, so the next pixel closes the image with a flagged write.
  task automatic test_reset_defaults();
    send_pixel(24'h000000);
    send_pixel(24'hFFFFFF);
    send_pixel(24'h070307);
    send_pixel(24'hF8FCF8);
    wait_for_writes();
    set_source(0, 0);
    send_pixel(24'h123456);
  endtask

  // Zero box sizes act as 1x1: only the first source pixel is kept.
  task automatic test_zero_box();
    wait_for_writes();
    set_box(0, 0, 0, 0);
    set_source(2, 2);
    send_pixel(24'hFF0000);
    send_pixel(24'h00FF00);
    send_pixel(24'h0000FF);
    send_pixel(24'hFFFFFF);
  endtask

  // Box at the far corners of its range puts everything off screen; then clip at each edge.
  task automatic test_clipping();
    wait_for_writes();
    set_source(1, 1);
    set_box(-1024, -1024, 1023, 1023);
    send_pixel(24'hFFFFFF);
    wait_for_writes();
    set_box(1023, 1023, 1023, 1023);
    send_pixel(24'hFFFFFF);
    // Top-left clip: only the final pixel lands, and it carries the last flag.
    wait_for_writes();
    set_source(2, 2);
    set_box(-1, -1, 2, 2);
    repeat (4) send_pixel(24'($urandom));
    // Bottom-right clip: the final pixel is off screen, so no write is flagged.
    wait_for_writes();
    set_box(ScreenWidth - 1, ScreenHeight - 1, 2, 2);
    repeat (4) send_pixel(24'($urandom));
  endtask

  // Largest source into the largest box, then cut the image short with a mid-image write.
  task automatic test_extreme_source();
    wait_for_writes();
    set_source(MaxSourceDim, MaxSourceDim);
    set_box(0, 0, 1023, 1023);
    repeat (5) send_pixel(24'($urandom));
    wait_for_writes();
    set_source(1, 1);
    send_pixel(24'($urandom));
  endtask

  // Hold the write port off for a long stretch while pixels keep coming, so the block
  // fills up and stalls its input.
  task automatic test_backpressure();
    wait_for_writes();
    set_source(8, 2);
    set_box(100, 100, 8, 2);
    hold_off_asked++;
    send_image();
  endtask

  // Random settings per phase: mostly small images and boxes so downscaling is common,
  // sometimes wide strips and full-range boxes; some phases stop part way into an image.
  task automatic test_random_phases();
    int base, sw, sh, bw, bh, bl, bt;
    base = pixel_beats;
    while (pixel_beats - base < RandomBeats) begin
      wait_for_writes();
      if (pixel_beats - base > RandomBeats - QuietTail) quiet_tail = 1'b1;
      if ($urandom_range(0, 7) == 0) begin
        sw = $urandom_range(13, 80);
        sh = $urandom_range(0, 2);
      end else begin
        sw = $urandom_range(0, 12);
        sh = $urandom_range(0, 12);
      end
      if ($urandom_range(0, 5) == 0) begin
        bw = $urandom_range(0, 1023);
        bh = $urandom_range(0, 1023);
      end else begin
        bw = $urandom_range(0, 16);
        bh = $urandom_range(0, 16);
      end
      if ($urandom_range(0, 5) == 0) begin
        bl = int'($urandom_range(0, 2047)) - 1024;
        bt = int'($urandom_range(0, 2047)) - 1024;
      end else begin
        bl = int'($urandom_range(0, 345)) - 20;
        bt = int'($urandom_range(0, 265)) - 20;
      end
      set_source(sw, sh);
      set_box(bl, bt, bw, bh);
      repeat ($urandom_range(1, 3)) send_image();
      // Leave an image open so the next phase's writes land mid-image.
      if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 20)) send_pixel(24'($urandom));
    end
  endtask

  // Write port: check each accepted beat, then choose ready for the next cycle.
  always @(posedge clk_i) begin
    if (rst_ni && wr_if.valid && wr_if.ready) begin
      if (pending_writes.size() == 0) begin
        $error("unexpected write: pixel_index %0d color %h frame_last %0d",
               wr_if.pixel_index, wr_if.color, wr_if.frame_last);
        fail_count++;
      end else begin
        head_write = pending_writes.pop_front();
        if (wr_if.pixel_index !== head_write.pixel_index) begin
          $error("pixel_index: expected %0d, actual %0d",
                 head_write.pixel_index, wr_if.pixel_index);
          fail_count++;
        end
        if (wr_if.color !== head_write.color) begin
          $error("color: expected %h, actual %h", head_write.color, wr_if.color);
          fail_count++;
        end
        if (wr_if.frame_last !== head_write.frame_last) begin
          $error("frame_last: expected %0d, actual %0d",
                 head_write.frame_last, wr_if.frame_last);
          fail_count++;
        end
        writes_checked++;
      end
    end
    if (!rst_ni) begin
      wr_if.ready <= 1'b0;
    end else begin
      if (hold_off_asked != hold_off_served) begin
        hold_off_served = hold_off_asked;
        stall_left = HoldOffCycles;
      end
      if (stall_left > 0) begin
        stall_left--;
        wr_if.ready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 6) == 0) begin
        stall_left = $urandom_range(1, 8) - 1;
        wr_if.ready <= 1'b0;
      end else begin
        wr_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    // Drive every input to a known value from time zero.
    rst_ni       = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_SOURCE_WIDTH;
    cfg_if.data  = '0;
    pix_if.valid = 1'b0;
    pix_if.red   = '0;
    pix_if.green = '0;
    pix_if.blue  = '0;
    wr_if.ready  = 1'b0;
    cfg_src_w    = SrcW'(RstSrcWidth);
    cfg_src_h    = SrcW'(RstSrcHeight);
    cfg_box_left = '0;
    cfg_box_top  = '0;
    cfg_box_w    = BoxW'(RstBoxWidth);
    cfg_box_h    = BoxW'(RstBoxHeight);
    img_col = 0; img_row = 0; dst_col = 0; dst_row = 0; pick_col = 0; pick_row = 0;
    fit_w = 0; fit_h = 0; org_x = 0; org_y = 0;
    fail_count = 0; writes_checked = 0; pixel_beats = 0; images_started = 0;
    cfg_writes = 0; cycle_count = 0; stall_left = 0;
    hold_off_asked = 0; hold_off_served = 0; quiet_tail = 1'b0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_zero_box();
    test_clipping();
    test_extreme_source();
    test_backpressure();
    test_random_phases();
    wait_for_writes();

    $display("Sent %0d source pixels over %0d images with %0d register writes;",
             pixel_beats, images_started, cfg_writes);
    $display("checked %0d writes; swept zero and full-range sizes, clipped boxes, mid-image changes.",
             writes_checked);
    if (fail_count == 0 && pending_writes.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/fsr_pkg.sv
hw/rtl/fsr_intf.sv
hw/rtl/fsr_front.sv
hw/rtl/fsr_muldiv.sv
hw/rtl/fsr_back.sv
hw/rtl/fit_scale_rgb_to_rgb565.sv
bench/fit_scale_rgb_to_rgb565_tb.sv
